### design/ptik_pkg.sv
// ----------------------------------------------------------------------------
// ptik_pkg: shared types, constants and functions
// Payload structs, fixed-point constants, the CORDIC arctangent table and the
// angle wrap used by the pan/tilt inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package ptik_pkg;

	// Input word: target point in signed Q16.16.
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pos_t;

	// Output word: both joint solutions in signed Q2.13 radians.
	typedef struct packed {
		logic signed [15:0] pan_first;
		logic signed [15:0] lift_first;
		logic signed [15:0] pan_second;
		logic signed [15:0] lift_second;
	} angles_t;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int SQRT_STAGES       = 32;
	localparam int NORM_STAGES       = 6;
	localparam int CW                = 42;  // CORDIC vector width
	localparam int AW                = 34;  // Q30 angle accumulator width
	localparam int QW                = 18;  // Q2.13 working width
	localparam int WW                = 20;  // width ahead of the wrap

	localparam logic signed [QW-1:0] PI_Q13      = 18'sd25736;
	localparam logic signed [QW-1:0] HALF_PI_Q13 = 18'sd12868;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	// Arctangent of 2^-i in Q30.
	function automatic logic [30:0] atan_q30(input int idx);
		logic [30:0] v;
		unique case (idx)
			0: v = 31'd843314857;
			1: v = 31'd497837829;
			2: v = 31'd263043837;
			3: v = 31'd133525159;
			4: v = 31'd67021687;
			5: v = 31'd33543516;
			6: v = 31'd16775851;
			7: v = 31'd8388437;
			8: v = 31'd4194283;
			9: v = 31'd2097149;
			10: v = 31'd1048576;
			11: v = 31'd524288;
			12: v = 31'd262144;
			13: v = 31'd131072;
			14: v = 31'd65536;
			15: v = 31'd32768;
			16: v = 31'd16384;
			17: v = 31'd8192;
			18: v = 31'd4096;
			19: v = 31'd2048;
			20: v = 31'd1024;
			21: v = 31'd512;
			22: v = 31'd256;
			23: v = 31'd128;
			24: v = 31'd64;
			25: v = 31'd32;
			26: v = 31'd16;
			27: v = 31'd8;
			28: v = 31'd4;
			29: v = 31'd2;
			30: v = 31'd1;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

	// Magnitude of a CORDIC vector component.
	function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
		return v[CW-1] ? CW'(-v) : v;
	endfunction

	// Wrap an angle into (-pi, pi] in Q2.13.
	function automatic logic signed [15:0] wrap_q13(input logic signed [WW-1:0] a);
		logic signed [WW-1:0] t;
		logic signed [WW-1:0] pi_w;
		pi_w = WW'(PI_Q13);
		t = a;
		if (t > pi_w) t = t - (pi_w + pi_w);
		if (t > pi_w) t = t - (pi_w + pi_w);
		if (t <= -pi_w) t = t + (pi_w + pi_w);
		if (t <= -pi_w) t = t + (pi_w + pi_w);
		return t[15:0];
	endfunction

endpackage

### design/ptik_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ptik_sqrt_cell: one digit of the integer square root
// Settles one result bit per cell; a row of these forms the root pipeline.
// ----------------------------------------------------------------------------
module ptik_sqrt_cell #(
	parameter int IDX = 0
) (
	input  logic        clk,
	input  logic [63:0] rem_in,
	input  logic [63:0] root_in,
	output logic [63:0] rem_out,
	output logic [63:0] root_out
);
	import ptik_pkg::*;

	localparam logic [63:0] TRIAL_BIT = 64'd1 << (62 - 2 * IDX);

	logic [63:0] trial;

	assign trial = root_in + TRIAL_BIT;

	// Subtract the trial value when it fits and record a one bit.
	always_ff @(posedge clk) begin
		if (rem_in >= trial) begin
			rem_out  <= rem_in - trial;
			root_out <= (root_in >> 1) + TRIAL_BIT;
		end else begin
			rem_out  <= rem_in;
			root_out <= root_in >> 1;
		end
	end

endmodule

### design/ptik_cordic_cell.sv
// ----------------------------------------------------------------------------
// ptik_cordic_cell: one CORDIC vectoring micro-rotation
// Rotates the vector toward the x axis and accumulates the angle in Q30.
// ----------------------------------------------------------------------------
module ptik_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                            clk,
	input  logic signed [ptik_pkg::CW-1:0]  x_in,
	input  logic signed [ptik_pkg::CW-1:0]  y_in,
	input  logic signed [ptik_pkg::AW-1:0]  ang_in,
	output logic signed [ptik_pkg::CW-1:0]  x_out,
	output logic signed [ptik_pkg::CW-1:0]  y_out,
	output logic signed [ptik_pkg::AW-1:0]  ang_out
);
	import ptik_pkg::*;

	localparam logic signed [AW-1:0] STEP = AW'({1'b0, atan_q30(IDX)});

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	// Direction follows the sign of y.
	always_ff @(posedge clk) begin
		if (y_in > 0) begin
			x_out   <= x_in + dx;
			y_out   <= y_in - dy;
			ang_out <= ang_in + STEP;
		end else begin
			x_out   <= x_in - dx;
			y_out   <= y_in + dy;
			ang_out <= ang_in - STEP;
		end
	end

endmodule

### design/ptik_atan2.sv
// ----------------------------------------------------------------------------
// ptik_atan2: pipelined four-quadrant arctangent
// Handles the axis cases, pre-rotates the left half plane, normalizes the
// vector in six shift stages and runs a row of CORDIC cells. Result is Q2.13.
// ----------------------------------------------------------------------------
module ptik_atan2 #(
	parameter int CORDIC_STAGES = ptik_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic signed [ptik_pkg::CW-1:0] y_in,
	input  logic signed [ptik_pkg::CW-1:0] x_in,
	output logic signed [ptik_pkg::QW-1:0] ang_out
);
	import ptik_pkg::*;

	localparam int SPEC_LEN = NORM_STAGES + CORDIC_STAGES + 1;

	logic signed [CW-1:0] nx_q   [0:NORM_STAGES];
	logic signed [CW-1:0] ny_q   [0:NORM_STAGES];
	logic signed [AW-1:0] nang_q [0:NORM_STAGES];
	logic                 spec_q [0:SPEC_LEN-1];
	logic signed [QW-1:0] sval_q [0:SPEC_LEN-1];
	logic signed [CW-1:0] cx     [0:CORDIC_STAGES];
	logic signed [CW-1:0] cy     [0:CORDIC_STAGES];
	logic signed [AW-1:0] ca     [0:CORDIC_STAGES];
	logic signed [AW-1:0] rnd;

	// Axis cases and pre-rotation of the left half plane.
	always_ff @(posedge clk) begin
		spec_q[0] <= (y_in == '0) || (x_in == '0);
		if (y_in == '0) begin
			sval_q[0] <= (x_in >= 0) ? QW'(0) : PI_Q13;
		end else begin
			sval_q[0] <= (y_in > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
		end
		if (x_in < 0) begin
			if (y_in >= 0) begin
				nx_q[0]   <= y_in;
				ny_q[0]   <= -x_in;
				nang_q[0] <= HALF_PI_Q30;
			end else begin
				nx_q[0]   <= -y_in;
				ny_q[0]   <= x_in;
				nang_q[0] <= -HALF_PI_Q30;
			end
		end else begin
			nx_q[0]   <= x_in;
			ny_q[0]   <= y_in;
			nang_q[0] <= '0;
		end
	end

	// Normalization: shifts the vector left by 16, 8, 4, 2, 1 and 1 bits while its larger component is small.
	for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
		localparam int SH = (j < NORM_STAGES - 1) ? (16 >> j) : 1;
		localparam int TH = (j < NORM_STAGES - 1) ? (32 - SH) : 32;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] mx;
		assign ax = mag_cw(nx_q[j]);
		assign ay = mag_cw(ny_q[j]);
		assign mx = (ax > ay) ? ax : ay;
		always_ff @(posedge clk) begin
			if (mx < (CW'(1) << TH)) begin
				nx_q[j+1] <= nx_q[j] <<< SH;
				ny_q[j+1] <= ny_q[j] <<< SH;
			end else begin
				nx_q[j+1] <= nx_q[j];
				ny_q[j+1] <= ny_q[j];
			end
			nang_q[j+1] <= nang_q[j];
		end
	end

	assign cx[0] = nx_q[NORM_STAGES];
	assign cy[0] = ny_q[NORM_STAGES];
	assign ca[0] = nang_q[NORM_STAGES];

	// Row of micro-rotation cells.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		ptik_cordic_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.x_in    (cx[i]),
			.y_in    (cy[i]),
			.ang_in  (ca[i]),
			.x_out   (cx[i+1]),
			.y_out   (cy[i+1]),
			.ang_out (ca[i+1])
		);
	end

	// Axis-case flag travels beside the vector.
	for (genvar k = 1; k < SPEC_LEN; k++) begin : g_spec
		always_ff @(posedge clk) begin
			spec_q[k] <= spec_q[k-1];
			sval_q[k] <= sval_q[k-1];
		end
	end

	// Round Q30 to Q2.13.
	assign rnd = ca[CORDIC_STAGES] + AW'(65536);

	always_ff @(posedge clk) begin
		if (spec_q[SPEC_LEN-1]) begin
			ang_out <= sval_q[SPEC_LEN-1];
		end else begin
			ang_out <= QW'(rnd >>> 17);
		end
	end

endmodule

### design/pan_tilt_two_solution_ik.sv
// ----------------------------------------------------------------------------
// pan_tilt_two_solution_ik: two-solution pan/lift inverse kinematics
// Squares and sums x and y, takes the root and runs two CORDIC rows.
// ----------------------------------------------------------------------------
// Usage: drive a target point on pos and raise start for one cycle; the word
// is taken at the clock edge where start is high and busy is low. busy stays
// low, so a new point may be offered every cycle.
// Each point yields one result word on angles, marked by done for exactly one
// cycle. Results leave in the order the points came in.
// Throughput is one point per cycle: every stage is a register row, the root
// uses 32 one-digit cells and each arctangent uses CORDIC_STAGES cells plus
// setup, normalization and rounding registers.
// The near-axis limit is written through the cfg channel, which is always
// ready; write it only while no point is in flight.
// Reset clears the valid pipeline, so done stays low until new points arrive,
// and sets the limit to 1. The receiver cannot stall; a word not taken in its
// cycle is gone.
// ----------------------------------------------------------------------------
module pan_tilt_two_solution_ik #(
	parameter int CORDIC_STAGES = ptik_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ptik_pkg::pos_t    pos,
	output logic              done,
	output ptik_pkg::angles_t angles,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);
	import ptik_pkg::*;

	localparam int ATAN_LAT = NORM_STAGES + CORDIC_STAGES + 2;
	localparam int DEPTH    = 2 + SQRT_STAGES + ATAN_LAT + 1;

	typedef struct packed {
		logic               near;
		logic               zpos;
		logic               ypos;
		logic signed [39:0] zs;
		logic [32:0]        ay;
		logic signed [32:0] nx;
	} side_t;

	typedef struct packed {
		logic near;
		logic zpos;
		logic ypos;
	} flags_t;

	logic [15:0]        limit_q;
	logic [DEPTH-1:0]   vld_q;
	logic [32:0]        ax_in;
	logic [32:0]        ay_in;
	logic               near_s1;
	logic signed [31:0] x_s1;
	logic signed [31:0] y_s1;
	logic signed [31:0] z_s1;
	logic [63:0]        xsq_s1;
	logic [63:0]        ysq_s1;
	logic [63:0]        r2;
	logic               r2_low;
	logic [63:0]        rad_s2;
	side_t              side_s2;
	logic [63:0]        rem   [0:SQRT_STAGES];
	logic [63:0]        root  [0:SQRT_STAGES];
	side_t              side1_q [0:SQRT_STAGES-1];
	flags_t             side2_q [0:ATAN_LAT-1];
	side_t              side_at;
	logic signed [QW-1:0] b1;
	logic signed [QW-1:0] b3;
	logic signed [WW-1:0] b3n;
	angles_t            res_d;
	angles_t            res_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Near-axis limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Valid bit for every stage of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DEPTH-2:0], start & ~busy};
		end
	end

	// Stage one: squares and the near-axis test.
	assign ax_in = pos.pos_x[31] ? 33'(-{pos.pos_x[31], pos.pos_x}) : {1'b0, pos.pos_x};
	assign ay_in = pos.pos_y[31] ? 33'(-{pos.pos_y[31], pos.pos_y}) : {1'b0, pos.pos_y};

	always_ff @(posedge clk) begin
		near_s1 <= (ax_in < {17'd0, limit_q}) && (ay_in < {17'd0, limit_q});
		x_s1    <= pos.pos_x;
		y_s1    <= pos.pos_y;
		z_s1    <= pos.pos_z;
		xsq_s1  <= ax_in * ax_in;
		ysq_s1  <= ay_in * ay_in;
	end

	// Stage two: radius squared, scaled up when small, and z scaled to match.
	assign r2     = xsq_s1 + ysq_s1;
	assign r2_low = (r2[63:46] == '0);

	always_ff @(posedge clk) begin
		rad_s2       <= r2_low ? {r2[47:0], 16'd0} : r2;
		side_s2.near <= near_s1;
		side_s2.zpos <= (z_s1 > 0);
		side_s2.ypos <= (y_s1 > 0);
		side_s2.zs   <= r2_low ? ({{8{z_s1[31]}}, z_s1} <<< 8) : 40'(z_s1);
		side_s2.ay   <= y_s1[31] ? 33'(-{y_s1[31], y_s1}) : {1'b0, y_s1};
		side_s2.nx   <= 33'(-{x_s1[31], x_s1});
	end

	// Integer square root, one bit per cell.
	assign rem[0]  = rad_s2;
	assign root[0] = '0;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		ptik_sqrt_cell #(.IDX(k)) u_cell (
			.clk      (clk),
			.rem_in   (rem[k]),
			.root_in  (root[k]),
			.rem_out  (rem[k+1]),
			.root_out (root[k+1])
		);
	end

	// Point data travels beside the root cells.
	always_ff @(posedge clk) begin
		side1_q[0] <= side_s2;
		for (int k = 1; k < SQRT_STAGES; k++) begin
			side1_q[k] <= side1_q[k-1];
		end
	end

	assign side_at = side1_q[SQRT_STAGES-1];

	// Elevation and azimuth arctangents run side by side.
	ptik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_elev (
		.clk     (clk),
		.y_in    (CW'(side_at.zs)),
		.x_in    (CW'(root[SQRT_STAGES][32:0])),
		.ang_out (b1)
	);

	ptik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_azim (
		.clk     (clk),
		.y_in    (CW'(side_at.ay)),
		.x_in    (CW'(side_at.nx)),
		.ang_out (b3)
	);

	// Flags follow the arctangent rows.
	always_ff @(posedge clk) begin
		side2_q[0] <= '{near: side_at.near, zpos: side_at.zpos, ypos: side_at.ypos};
		for (int k = 1; k < ATAN_LAT; k++) begin
			side2_q[k] <= side2_q[k-1];
		end
	end

	// Combine into both solutions and wrap.
	assign b3n = side2_q[ATAN_LAT-1].ypos ? -WW'(b3) : WW'(b3);

	always_comb begin
		if (side2_q[ATAN_LAT-1].near) begin
			res_d.pan_first   = '0;
			res_d.pan_second  = '0;
			res_d.lift_first  = side2_q[ATAN_LAT-1].zpos ? -16'(HALF_PI_Q13)
				: 16'(HALF_PI_Q13);
			res_d.lift_second = res_d.lift_first;
		end else begin
			res_d.pan_first   = wrap_q13(b3n);
			res_d.lift_first  = wrap_q13(-WW'(b1));
			res_d.pan_second  = wrap_q13(b3n + WW'(PI_Q13));
			res_d.lift_second = wrap_q13(WW'(b1) - WW'(PI_Q13));
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done   = vld_q[DEPTH-1];
	assign angles = res_q;

	// Every accepted word comes out after the fixed latency.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##DEPTH done)
		else $error("result word missing after accepted point");

	// No result without an accepted point.
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, DEPTH))
		else $error("result word without an accepted point");

	// Delivered pan angles are wrapped into (-pi, pi].
	a_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angles.pan_first <= 16'(PI_Q13) && angles.pan_first > -16'(PI_Q13)
			&& angles.pan_second <= 16'(PI_Q13) && angles.pan_second > -16'(PI_Q13)))
		else $error("pan angle outside wrap range");

endmodule
